// File: sv/signed_bcd_arithmetic_unit_core_defines.svh
// Assertion macros for the signed BCD arithmetic unit.
`ifndef SIGNED_BCD_ARITHMETIC_UNIT_CORE_DEFINES_SVH
`define SIGNED_BCD_ARITHMETIC_UNIT_CORE_DEFINES_SVH

// Checked on clk_i, off while reset is held.
`define SBAU_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checked on clk_i, also during reset.
`define SBAU_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// File: sv/sbau_pkg.sv
`default_nettype none
package sbau_pkg;

  localparam int unsigned DigitsIn  = 19;
  localparam int unsigned DigitsOut = 38;
  localparam int unsigned BinW      = 64;
  localparam int unsigned WideW     = 128;

  localparam logic [1:0] CMD_ADD = 2'd0;
  localparam logic [1:0] CMD_SUB = 2'd1;
  localparam logic [1:0] CMD_MUL = 2'd2;
  localparam logic [1:0] CMD_DIV = 2'd3;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_CONV,
    OP_SETUP,
    OP_MUL,
    OP_DIV,
    OP_FINISH,
    OP_DABBLE
  } dp_op_e;

  typedef struct packed {
    dp_op_e op;
  } dp_ctl_t;

  typedef struct packed {
    logic is_mul;
    logic is_div;
  } dp_stat_t;

endpackage
`default_nettype wire

// File: sv/signed_bcd_arithmetic_unit_core.sv
`default_nettype none
// Sign-magnitude BCD ALU, 19-digit operands, 38-digit result. A command beat is
// taken when start is high and busy low; busy then stays high through the result
// beat, which shows for one cycle on result_valid_o and cannot be stalled.
// Add and subtract run 19 digit-conversion steps, one setup and one finish step
// and 128 double-dabble steps before the result cycle; multiply and divide add
// 64 shift-add or restoring-divide steps after the setup step. Busy drops at
// the edge that ends the result cycle, so one item at a time.
module signed_bcd_arithmetic_unit_core (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [1:0]  command_i,
  input  wire logic        a_negative_i,
  input  wire logic [63:0] a_low_digits_i,
  input  wire logic [11:0] a_high_digits_i,
  input  wire logic        b_negative_i,
  input  wire logic [63:0] b_low_digits_i,
  input  wire logic [11:0] b_high_digits_i,
  output logic             result_valid_o,
  output logic             result_negative_o,
  output logic [63:0]      result_low_digits_o,
  output logic [63:0]      result_mid_digits_o,
  output logic [23:0]      result_high_digits_o,
  output logic             divide_by_zero_o
);

  sbau_pkg::dp_ctl_t  ctl;
  sbau_pkg::dp_stat_t stat;

  sbau_ctrl u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .result_valid_o (result_valid_o),
    .stat_i         (stat),
    .ctl_o          (ctl)
  );

  sbau_datapath u_dp (
    .clk_i                (clk_i),
    .ctl_i                (ctl),
    .stat_o               (stat),
    .command_i            (command_i),
    .a_negative_i         (a_negative_i),
    .a_low_digits_i       (a_low_digits_i),
    .a_high_digits_i      (a_high_digits_i),
    .b_negative_i         (b_negative_i),
    .b_low_digits_i       (b_low_digits_i),
    .b_high_digits_i      (b_high_digits_i),
    .result_negative_o    (result_negative_o),
    .result_low_digits_o  (result_low_digits_o),
    .result_mid_digits_o  (result_mid_digits_o),
    .result_high_digits_o (result_high_digits_o),
    .divide_by_zero_o     (divide_by_zero_o)
  );

endmodule
`default_nettype wire

// File: sv/sbau_datapath.sv
`default_nettype none
module sbau_datapath (
  input  wire logic               clk_i,
  input  wire sbau_pkg::dp_ctl_t  ctl_i,
  output sbau_pkg::dp_stat_t      stat_o,
  input  wire logic [1:0]         command_i,
  input  wire logic               a_negative_i,
  input  wire logic [63:0]        a_low_digits_i,
  input  wire logic [11:0]        a_high_digits_i,
  input  wire logic               b_negative_i,
  input  wire logic [63:0]        b_low_digits_i,
  input  wire logic [11:0]        b_high_digits_i,
  output logic                    result_negative_o,
  output logic [63:0]             result_low_digits_o,
  output logic [63:0]             result_mid_digits_o,
  output logic [23:0]             result_high_digits_o,
  output logic                    divide_by_zero_o
);

  localparam int unsigned InW  = 4 * sbau_pkg::DigitsIn;
  localparam int unsigned BcdW = 4 * sbau_pkg::DigitsOut;

  logic [1:0]                   cmd_q, cmd_d;
  logic                         sa_q, sa_d, sb_q, sb_d;
  logic [InW-1:0]               da_q, da_d, db_q, db_d;
  logic [sbau_pkg::BinW-1:0]    va_q, va_d, vb_q, vb_d, rem_q, rem_d;
  logic [sbau_pkg::WideW-1:0]   wk_q, wk_d;
  logic                         neg_q, neg_d, dz_q, dz_d;
  logic [BcdW-1:0]              bcd_q, bcd_d;

  logic                         sbe;
  logic [sbau_pkg::BinW:0]      addsub;
  logic [sbau_pkg::BinW:0]      mul_sum;
  logic [sbau_pkg::BinW:0]      div_sh, div_diff;
  logic                         div_ge;
  logic [sbau_pkg::WideW-1:0]   fin_wk;
  logic                         fin_neg, fin_dz;
  logic [BcdW-1:0]              bcd_adj;

  assign stat_o.is_mul = (cmd_q == sbau_pkg::CMD_MUL);
  assign stat_o.is_div = (cmd_q == sbau_pkg::CMD_DIV);

  always_comb begin
    sbe = sb_q ^ (cmd_q == sbau_pkg::CMD_SUB);
    if (sa_q == sbe) begin
      addsub = {1'b0, va_q} + {1'b0, vb_q};
    end else if (va_q >= vb_q) begin
      addsub = {1'b0, va_q - vb_q};
    end else begin
      addsub = {1'b0, vb_q - va_q};
    end
  end

  assign mul_sum  = {1'b0, wk_q[127:64]} + (wk_q[0] ? {1'b0, va_q} : '0);
  assign div_sh   = {rem_q, va_q[63]};
  assign div_ge   = div_sh >= {1'b0, vb_q};
  assign div_diff = div_sh - {1'b0, vb_q};

  always_comb begin
    fin_wk  = wk_q;
    fin_neg = neg_q;
    fin_dz  = 1'b0;
    priority if (cmd_q == sbau_pkg::CMD_DIV) begin
      if (vb_q == '0) begin
        fin_wk = '0;
        fin_dz = 1'b1;
      end else begin
        fin_wk = {64'd0, va_q};
      end
      fin_neg = sa_q ^ sb_q;
    end else if (cmd_q == sbau_pkg::CMD_MUL) begin
      fin_neg = sa_q ^ sb_q;
    end else begin
      fin_neg = neg_q;
    end
    if (fin_wk == '0) begin
      fin_neg = 1'b0;
    end
  end

  always_comb begin
    for (int i = 0; i < sbau_pkg::DigitsOut; i++) begin
      bcd_adj[4*i +: 4] = (bcd_q[4*i +: 4] >= 4'd5) ? bcd_q[4*i +: 4] + 4'd3
                                                   : bcd_q[4*i +: 4];
    end
  end

  always_comb begin
    cmd_d = cmd_q; sa_d = sa_q; sb_d = sb_q; da_d = da_q; db_d = db_q;
    va_d = va_q; vb_d = vb_q; rem_d = rem_q; wk_d = wk_q;
    neg_d = neg_q; dz_d = dz_q; bcd_d = bcd_q;
    unique case (ctl_i.op)
      sbau_pkg::OP_LOAD: begin
        cmd_d = command_i;
        sa_d  = a_negative_i;
        sb_d  = b_negative_i;
        da_d  = {a_high_digits_i, a_low_digits_i};
        db_d  = {b_high_digits_i, b_low_digits_i};
        va_d  = '0;
        vb_d  = '0;
      end
      sbau_pkg::OP_CONV: begin
        va_d = (va_q << 3) + (va_q << 1) + {60'd0, da_q[InW-1 -: 4]};
        vb_d = (vb_q << 3) + (vb_q << 1) + {60'd0, db_q[InW-1 -: 4]};
        da_d = da_q << 4;
        db_d = db_q << 4;
      end
      sbau_pkg::OP_SETUP: begin
        rem_d = '0;
        if (cmd_q == sbau_pkg::CMD_MUL) begin
          wk_d = {64'd0, vb_q};
        end else begin
          wk_d  = {63'd0, addsub};
          neg_d = (sa_q == sbe) ? sa_q : ((va_q >= vb_q) ? sa_q : sbe);
        end
      end
      sbau_pkg::OP_MUL: begin
        wk_d = {mul_sum, wk_q[63:1]};
      end
      sbau_pkg::OP_DIV: begin
        rem_d = div_ge ? div_diff[63:0] : div_sh[63:0];
        va_d  = {va_q[62:0], div_ge};
      end
      sbau_pkg::OP_FINISH: begin
        wk_d  = fin_wk;
        neg_d = fin_neg;
        dz_d  = fin_dz;
        bcd_d = '0;
      end
      sbau_pkg::OP_DABBLE: begin
        bcd_d = {bcd_adj[BcdW-2:0], wk_q[127]};
        wk_d  = wk_q << 1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    cmd_q <= cmd_d; sa_q <= sa_d; sb_q <= sb_d; da_q <= da_d; db_q <= db_d;
    va_q <= va_d; vb_q <= vb_d; rem_q <= rem_d; wk_q <= wk_d;
    neg_q <= neg_d; dz_q <= dz_d; bcd_q <= bcd_d;
  end

  assign result_negative_o    = neg_q;
  assign result_low_digits_o  = bcd_q[63:0];
  assign result_mid_digits_o  = bcd_q[127:64];
  assign result_high_digits_o = bcd_q[151:128];
  assign divide_by_zero_o     = dz_q;

endmodule
`default_nettype wire

// File: sv/sbau_ctrl.sv
`default_nettype none
module sbau_ctrl (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start,
  output logic                    busy,
  output logic                    result_valid_o,
  input  wire sbau_pkg::dp_stat_t stat_i,
  output sbau_pkg::dp_ctl_t       ctl_o
);

  typedef enum logic [2:0] {
    S_IDLE, S_CONV, S_SETUP, S_MUL, S_DIV, S_FINISH, S_DABBLE, S_OUT
  } state_e;

  localparam logic [6:0] ConvLast = 7'(sbau_pkg::DigitsIn - 1);
  localparam logic [6:0] StepLast = 7'(sbau_pkg::BinW - 1);
  localparam logic [6:0] DabLast  = 7'(sbau_pkg::WideW - 1);

  state_e     state_q;
  logic [6:0] cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
    end else begin
      unique case (state_q)
        S_IDLE: begin
          cnt_q <= '0;
          if (start) state_q <= S_CONV;
        end
        S_CONV: begin
          cnt_q <= cnt_q + 7'd1;
          if (cnt_q == ConvLast) state_q <= S_SETUP;
        end
        S_SETUP: begin
          cnt_q <= '0;
          priority if (stat_i.is_mul) state_q <= S_MUL;
          else if (stat_i.is_div)     state_q <= S_DIV;
          else                        state_q <= S_FINISH;
        end
        S_MUL, S_DIV: begin
          cnt_q <= cnt_q + 7'd1;
          if (cnt_q == StepLast) state_q <= S_FINISH;
        end
        S_FINISH: begin
          cnt_q   <= '0;
          state_q <= S_DABBLE;
        end
        S_DABBLE: begin
          cnt_q <= cnt_q + 7'd1;
          if (cnt_q == DabLast) state_q <= S_OUT;
        end
        S_OUT: state_q <= S_IDLE;
        default: state_q <= S_IDLE;
      endcase
    end
  end

  always_comb begin
    unique case (state_q)
      S_IDLE:   ctl_o.op = start ? sbau_pkg::OP_LOAD : sbau_pkg::OP_NONE;
      S_CONV:   ctl_o.op = sbau_pkg::OP_CONV;
      S_SETUP:  ctl_o.op = sbau_pkg::OP_SETUP;
      S_MUL:    ctl_o.op = sbau_pkg::OP_MUL;
      S_DIV:    ctl_o.op = sbau_pkg::OP_DIV;
      S_FINISH: ctl_o.op = sbau_pkg::OP_FINISH;
      S_DABBLE: ctl_o.op = sbau_pkg::OP_DABBLE;
      default:  ctl_o.op = sbau_pkg::OP_NONE;
    endcase
  end

  assign busy           = (state_q != S_IDLE);
  assign result_valid_o = (state_q == S_OUT);

endmodule
`default_nettype wire

// File: sv/sbau_checker.sv
`default_nettype none
`include "signed_bcd_arithmetic_unit_core_defines.svh"
module sbau_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        start,
  input wire logic        busy,
  input wire logic        result_valid_o,
  input wire logic        result_negative_o,
  input wire logic [63:0] result_low_digits_o,
  input wire logic [63:0] result_mid_digits_o,
  input wire logic [23:0] result_high_digits_o,
  input wire logic        divide_by_zero_o
);

  logic res_zero;
  assign res_zero = (result_low_digits_o == '0) && (result_mid_digits_o == '0) &&
                    (result_high_digits_o == '0);

  `SBAU_ASSERT(a_accept_busy, start && !busy |=> busy, "accepted beat did not raise busy")
  `SBAU_ASSERT(a_one_beat, result_valid_o |=> !result_valid_o && !busy,
               "result beat longer than one cycle or busy stuck")
  `SBAU_ASSERT(a_no_neg_zero, result_valid_o && res_zero |-> !result_negative_o,
               "negative zero result")
  `SBAU_ASSERT(a_dz_zero, result_valid_o && divide_by_zero_o |-> res_zero,
               "divide by zero with nonzero result")
  `SBAU_ASSERT_ALWAYS(a_reset_idle, !rst_ni |-> !busy && !result_valid_o,
                      "busy or result during reset")

endmodule

bind signed_bcd_arithmetic_unit_core sbau_checker u_sbau_checker (
  .clk_i                (clk_i),
  .rst_ni               (rst_ni),
  .start                (start),
  .busy                 (busy),
  .result_valid_o       (result_valid_o),
  .result_negative_o    (result_negative_o),
  .result_low_digits_o  (result_low_digits_o),
  .result_mid_digits_o  (result_mid_digits_o),
  .result_high_digits_o (result_high_digits_o),
  .divide_by_zero_o     (divide_by_zero_o)
);
`default_nettype wire

// File: test/signed_bcd_arithmetic_unit_core_checker.sv
`default_nettype none
module signed_bcd_arithmetic_unit_core_checker (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start,
  input  wire logic        busy,
  input  wire logic [1:0]  command_i,
  input  wire logic        a_negative_i,
  input  wire logic [63:0] a_low_digits_i,
  input  wire logic [11:0] a_high_digits_i,
  input  wire logic        b_negative_i,
  input  wire logic [63:0] b_low_digits_i,
  input  wire logic [11:0] b_high_digits_i,
  input  wire logic        result_valid_o,
  input  wire logic        result_negative_o,
  input  wire logic [63:0] result_low_digits_o,
  input  wire logic [63:0] result_mid_digits_o,
  input  wire logic [23:0] result_high_digits_o,
  input  wire logic        divide_by_zero_o,
  output int               errors_o,
  output int               outstanding_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic        negative;
    logic [63:0] low;
    logic [63:0] mid;
    logic [23:0] high;
    logic        div_zero;
  } bcd_result_t;

  bcd_result_t expected_results[$];
  int errors;

  assign errors_o      = errors;
  assign outstanding_o = expected_results.size();

  function automatic logic [63:0] digits_value(logic [63:0] lo, logic [11:0] hi);
    logic [63:0] v;
    v = '0;
    for (int i = 2; i >= 0; i--) v = v * 64'd10 + hi[4*i +: 4];
    for (int i = 15; i >= 0; i--) v = v * 64'd10 + lo[4*i +: 4];
    return v;
  endfunction

  function automatic bcd_result_t compute_bcd_result(
      logic [1:0] cmd, logic sa, logic [63:0] alo, logic [11:0] ahi,
      logic sb, logic [63:0] blo, logic [11:0] bhi);
    logic [127:0] ma, mb, mag;
    logic [151:0] digits;
    bcd_result_t r;
    ma = {64'd0, digits_value(alo, ahi)};
    mb = {64'd0, digits_value(blo, bhi)};
    mag = '0;
    r = '0;
    case (cmd)
      sbau_pkg::CMD_ADD, sbau_pkg::CMD_SUB: begin
        if (cmd == sbau_pkg::CMD_SUB) sb = !sb;
        if (sa == sb) begin
          mag = ma + mb;
          r.negative = sa;
        end else if (ma >= mb) begin
          mag = ma - mb;
          r.negative = sa;
        end else begin
          mag = mb - ma;
          r.negative = sb;
        end
      end
      sbau_pkg::CMD_MUL: begin
        mag = ma * mb;
        r.negative = sa ^ sb;
      end
      default: begin
        if (mb == 0) begin
          r.div_zero = 1'b1;
        end else begin
          mag = ma / mb;
          r.negative = sa ^ sb;
        end
      end
    endcase
    if (mag == 0) r.negative = 1'b0;
    for (int d = 0; d < 38; d++) begin
      digits[4*d +: 4] = 4'(mag % 128'd10);
      mag = mag / 128'd10;
    end
    r.low  = digits[63:0];
    r.mid  = digits[127:64];
    r.high = digits[151:128];
    return r;
  endfunction

  initial errors = 0;

  always @(posedge clk_i) begin
    bcd_result_t exp_r;
    if (rst_ni) begin
      if (result_valid_o) begin
        if (expected_results.size() == 0) begin
          $error("result beat with no command pending");
          errors++;
        end else begin
          exp_r = expected_results.pop_front();
          if (result_negative_o !== exp_r.negative) begin
            $error("result_negative: expected %0b, got %0b", exp_r.negative,
                   result_negative_o);
            errors++;
          end
          if (result_low_digits_o !== exp_r.low) begin
            $error("result_low_digits: expected %h, got %h", exp_r.low, result_low_digits_o);
            errors++;
          end
          if (result_mid_digits_o !== exp_r.mid) begin
            $error("result_mid_digits: expected %h, got %h", exp_r.mid, result_mid_digits_o);
            errors++;
          end
          if (result_high_digits_o !== exp_r.high) begin
            $error("result_high_digits: expected %h, got %h", exp_r.high,
                   result_high_digits_o);
            errors++;
          end
          if (divide_by_zero_o !== exp_r.div_zero) begin
            $error("divide_by_zero: expected %0b, got %0b", exp_r.div_zero,
                   divide_by_zero_o);
            errors++;
          end
        end
      end
      if (start && !busy) begin
        exp_r = compute_bcd_result(command_i, a_negative_i,
            a_low_digits_i, a_high_digits_i, b_negative_i, b_low_digits_i,
            b_high_digits_i);
        expected_results = {expected_results, exp_r};
      end
    end
  end
endmodule
`default_nettype wire

// File: test/signed_bcd_arithmetic_unit_core_tb.sv
`default_nettype none
module signed_bcd_arithmetic_unit_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  logic        clk_i;
  logic        rst_ni;
  logic        start;
  logic        busy;
  logic [1:0]  command_i;
  logic        a_negative_i;
  logic [63:0] a_low_digits_i;
  logic [11:0] a_high_digits_i;
  logic        b_negative_i;
  logic [63:0] b_low_digits_i;
  logic [11:0] b_high_digits_i;
  logic        result_valid_o;
  logic        result_negative_o;
  logic [63:0] result_low_digits_o;
  logic [63:0] result_mid_digits_o;
  logic [23:0] result_high_digits_o;
  logic        divide_by_zero_o;
  int          errors;
  int          outstanding;
  int          idle_pct;

  localparam logic [75:0] MaxBcd  = {12'h999, 64'h9999_9999_9999_9999};
  localparam logic [75:0] AllOnes = '1;

  signed_bcd_arithmetic_unit_core uut (.*);
  signed_bcd_arithmetic_unit_core_checker chk (
    .clk_i, .rst_ni, .start, .busy, .command_i, .a_negative_i, .a_low_digits_i,
    .a_high_digits_i, .b_negative_i, .b_low_digits_i, .b_high_digits_i,
    .result_valid_o, .result_negative_o, .result_low_digits_o, .result_mid_digits_o,
    .result_high_digits_o, .divide_by_zero_o, .errors_o(errors),
    .outstanding_o(outstanding)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    #20ms;
    $display("== FAIL ==");
    $finish;
  end

  function automatic logic [75:0] rand_operand();
    logic [75:0] v;
    int ndig;
    v = '0;
    if ($urandom_range(0, 19) == 0) return 76'({$urandom, $urandom, $urandom});
    ndig = $urandom_range(0, 19);
    for (int i = 0; i < ndig; i++)
      v[4*i +: 4] = ($urandom_range(0, 15) == 0) ? 4'($urandom_range(10, 15))
                                                 : 4'($urandom_range(0, 9));
    return v;
  endfunction

  // drive one command beat and hold it until accepted
  task automatic issue_cmd(logic [1:0] cmd, logic sa, logic [75:0] a,
                           logic sb, logic [75:0] b);
    int gap;
    if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      gap = $urandom_range(1, 20);
      repeat (gap) @(posedge clk_i);
    end
    start           <= 1'b1;
    command_i       <= cmd;
    a_negative_i    <= sa;
    a_low_digits_i  <= a[63:0];
    a_high_digits_i <= a[75:64];
    b_negative_i    <= sb;
    b_low_digits_i  <= b[63:0];
    b_high_digits_i <= b[75:64];
    do @(posedge clk_i); while (busy);
  endtask

  initial begin
    logic [75:0] a, b;
    start = 1'b0;
    command_i = sbau_pkg::CMD_ADD;
    a_negative_i = 1'b0;
    a_low_digits_i = '0;
    a_high_digits_i = '0;
    b_negative_i = 1'b0;
    b_low_digits_i = '0;
    b_high_digits_i = '0;
    idle_pct = 0;
    rst_ni = 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    issue_cmd(sbau_pkg::CMD_ADD, 1'b1, '0, 1'b1, '0);
    issue_cmd(sbau_pkg::CMD_SUB, 1'b1, 76'h123, 1'b1, 76'h123);
    issue_cmd(sbau_pkg::CMD_SUB, 1'b0, 76'h5, 1'b0, 76'h123);
    issue_cmd(sbau_pkg::CMD_ADD, 1'b0, MaxBcd, 1'b0, MaxBcd);
    issue_cmd(sbau_pkg::CMD_ADD, 1'b1, MaxBcd, 1'b0, 76'h1);
    issue_cmd(sbau_pkg::CMD_SUB, 1'b1, MaxBcd, 1'b0, MaxBcd);
    issue_cmd(sbau_pkg::CMD_MUL, 1'b0, MaxBcd, 1'b1, MaxBcd);
    issue_cmd(sbau_pkg::CMD_MUL, 1'b1, '0, 1'b0, MaxBcd);
    issue_cmd(sbau_pkg::CMD_MUL, 1'b1, AllOnes, 1'b1, AllOnes);
    issue_cmd(sbau_pkg::CMD_ADD, 1'b0, AllOnes, 1'b0, AllOnes);
    issue_cmd(sbau_pkg::CMD_SUB, 1'b0, AllOnes, 1'b1, AllOnes);
    issue_cmd(sbau_pkg::CMD_DIV, 1'b0, MaxBcd, 1'b1, '0);
    issue_cmd(sbau_pkg::CMD_DIV, 1'b1, MaxBcd, 1'b0, '0);
    issue_cmd(sbau_pkg::CMD_DIV, 1'b1, 76'h7, 1'b0, 76'h9);
    issue_cmd(sbau_pkg::CMD_DIV, 1'b1, MaxBcd, 1'b0, 76'h3);
    issue_cmd(sbau_pkg::CMD_DIV, 1'b0, MaxBcd, 1'b0, MaxBcd);
    issue_cmd(sbau_pkg::CMD_DIV, 1'b0, AllOnes, 1'b1, 76'h1);
    issue_cmd(sbau_pkg::CMD_DIV, 1'b1, 76'hA, 1'b1, 76'hF);
    issue_cmd(sbau_pkg::CMD_MUL, 1'b0, 76'h1, 1'b1, 76'hF);

    for (int i = 0; i < 1500; i++) begin
      case ((i * 4) / 1500)
        0: idle_pct = 0;
        1: idle_pct = 54;
        2: idle_pct = 21;
        default: idle_pct = 0;
      endcase
      a = rand_operand();
      b = rand_operand();
      issue_cmd(2'($urandom_range(0, 3)), 1'($urandom), a, 1'($urandom), b);
    end
    start <= 1'b0;

    while (outstanding != 0) @(posedge clk_i);
    repeat (250) @(posedge clk_i);
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end
endmodule
`default_nettype wire
